// File: sv/imm_pkg.sv
// ---------------------------------------------------------------------------
// imm_pkg: shared types and constants for the integer matrix multiplier
// Item structs, command codes, register indexes and controller/datapath
// interface structs.
// ---------------------------------------------------------------------------
`default_nettype none

package imm_pkg;

  localparam int MAX_DIM = 8;
  localparam int ELEM_W  = 32;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int DIM_W   = 4;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MUL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [ELEM_W-1:0] out_value;
    logic                     last;
  } out_item_t;

  // Tag that travels alongside one multiply-accumulate beat
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             final_k;
    logic             zero;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  typedef struct packed {
    logic             load_a;
    logic             load_b;
    logic [IDX_W-1:0] k;
    tag_t             tag;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_empty;
  } dp_status_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return ADDR_W'(r * MAX_DIM) + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

// File: sv/imm_ram.sv
// ---------------------------------------------------------------------------
// imm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/imm_datapath.sv
// ---------------------------------------------------------------------------
// imm_datapath: element stores and multiply-accumulate pipeline
// Two RAMs hold A and B; read data feeds a registered multiplier and an
// accumulator that emits one product element per final inner step.
// ---------------------------------------------------------------------------
`default_nettype none

module imm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  imm_pkg::in_item_t   item,
  input  imm_pkg::dp_cmd_t    dp_cmd,
  output imm_pkg::dp_status_t dp_status,
  output logic                result_strobe,
  output imm_pkg::out_item_t  result
);

  import imm_pkg::*;

  logic [ELEM_W-1:0] a_rd;
  logic [ELEM_W-1:0] b_rd;
  logic [ELEM_W-1:0] prod;
  logic [ELEM_W-1:0] acc;
  logic [ELEM_W-1:0] sum;
  tag_t              s1;
  tag_t              s2;

  imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (dp_cmd.load_a),
    .waddr (addr_of(item.row_index, item.col_index)),
    .wdata (item.elem_value),
    .raddr (addr_of(dp_cmd.tag.row, dp_cmd.k)),
    .rdata (a_rd)
  );

  imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (dp_cmd.load_b),
    .waddr (addr_of(item.row_index, item.col_index)),
    .wdata (item.elem_value),
    .raddr (addr_of(dp_cmd.k, dp_cmd.tag.col)),
    .rdata (b_rd)
  );

  // restart the sum on the first inner step of each element
  assign sum = (s2.first ? '0 : acc) + prod;

  assign dp_status.pipe_empty = !s1.valid && !s2.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1            <= '0;
      s2            <= '0;
      result_strobe <= 1'b0;
    end else begin
      s1            <= dp_cmd.tag;
      s2            <= s1;
      result_strobe <= s2.valid && s2.final_k;
    end
  end

  always_ff @(posedge clk) begin
    // low half of the product is the wrapped value
    prod <= s1.zero ? '0 : a_rd * b_rd;
    if (s2.valid) begin
      acc <= sum;
    end
    if (s2.valid && s2.final_k) begin
      result.out_row   <= s2.row;
      result.out_col   <= s2.col;
      result.out_value <= sum;
      result.last      <= s2.last;
    end
  end

`ifndef SYNTHESIS
  a_strobe_from_final: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(s2.valid && s2.final_k))
    else $error("result beat without a final inner step");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    s2.valid |-> $past(s1.valid))
    else $error("product stage valid without read stage");
`endif

endmodule

`default_nettype wire

// File: sv/imm_ctrl.sv
// ---------------------------------------------------------------------------
// imm_ctrl: sequencer for the matrix multiplier
// Holds the dimension registers, accepts commands and walks row, column
// and inner counters, issuing one multiply-accumulate beat per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module imm_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [imm_pkg::CMD_W-1:0]     command,
  input  logic                          cfg_we,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imm_pkg::DIM_W-1:0]     cfg_data,
  input  imm_pkg::dp_status_t           dp_status,
  output imm_pkg::dp_cmd_t              dp_cmd,
  output logic                          busy
);

  import imm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [DIM_W-1:0] a_rows;
  logic [DIM_W-1:0] inner_dim;
  logic [DIM_W-1:0] b_cols;
  logic [DIM_W-1:0] nr;
  logic [DIM_W-1:0] nk;
  logic [DIM_W-1:0] nc;
  logic [IDX_W-1:0] row_cnt;
  logic [IDX_W-1:0] col_cnt;
  logic [IDX_W-1:0] k_cnt;
  logic             accept;
  logic             go;
  logic             row_last;
  logic             col_last;
  logic             k_last;

  assign nr = clamp_dim(a_rows);
  assign nk = clamp_dim(inner_dim);
  assign nc = clamp_dim(b_cols);

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign go     = accept && (command == CMD_MUL) && (nr != '0) && (nc != '0);

  assign row_last = (DIM_W'(row_cnt) + DIM_W'(1)) == nr;
  assign col_last = (DIM_W'(col_cnt) + DIM_W'(1)) == nc;
  // an empty inner dimension still takes one beat, with a zero product
  assign k_last   = (nk == '0) || ((DIM_W'(k_cnt) + DIM_W'(1)) == nk);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (go) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_last && col_last && row_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dp_status.pipe_empty) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows    <= DIM_W'(MAX_DIM);
      inner_dim <= DIM_W'(MAX_DIM);
      b_cols    <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_A_ROWS:    a_rows    <= cfg_data;
        CFG_INNER_DIM: inner_dim <= cfg_data;
        CFG_B_COLS:    b_cols    <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
      k_cnt   <= '0;
    end else if (go) begin
      row_cnt <= '0;
      col_cnt <= '0;
      k_cnt   <= '0;
    end else if (state == ST_RUN) begin
      if (!k_last) begin
        k_cnt <= k_cnt + 1'b1;
      end else begin
        k_cnt <= '0;
        if (!col_last) begin
          col_cnt <= col_cnt + 1'b1;
        end else begin
          col_cnt <= '0;
          row_cnt <= row_cnt + 1'b1;
        end
      end
    end
  end

  always_comb begin
    dp_cmd.load_a      = accept && (command == CMD_LOAD_A);
    dp_cmd.load_b      = accept && (command == CMD_LOAD_B);
    dp_cmd.k           = k_cnt;
    dp_cmd.tag.valid   = (state == ST_RUN);
    dp_cmd.tag.first   = (k_cnt == '0);
    dp_cmd.tag.final_k = k_last;
    dp_cmd.tag.zero    = (nk == '0);
    dp_cmd.tag.last    = row_last && col_last;
    dp_cmd.tag.row     = row_cnt;
    dp_cmd.tag.col     = col_cnt;
  end

`ifndef SYNTHESIS
  a_cnt_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> ((DIM_W'(row_cnt) < nr) && (DIM_W'(col_cnt) < nc)))
    else $error("element counter beyond the product size");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> dp_status.pipe_empty)
    else $error("idle with beats still in the pipeline");
`endif

endmodule

`default_nettype wire

// File: sv/integer_matrix_multiply_top.sv
// ---------------------------------------------------------------------------
// integer_matrix_multiply_top: integer matrix multiplier
// Loads A and B element by element, then emits C = A * B row by row with
// 32-bit wrap-around; the final element of a run is flagged.
//
//   channel   handshake              payload
//   input     start & !busy          item   (command, row/col index, value)
//   result    result_strobe          result (row, col, value, last)
//   config    cfg_we                 cfg_index, cfg_data
//
// A load writes its store directly; a new item can follow in the next cycle.
// A multiply holds busy while the single multiply-accumulate unit walks every
// row, column and inner index (an empty inner dimension gets a zero product),
// then while the RAM read and multiplier registers drain.
// Reset sets all three dimensions to 8; the stores keep no reset value.
// Results are shown for one cycle each; the receiver cannot stall them.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_matrix_multiply_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  imm_pkg::in_item_t             item,
  output logic                          result_strobe,
  output imm_pkg::out_item_t            result,
  input  logic                          cfg_we,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imm_pkg::DIM_W-1:0]     cfg_data
);

  import imm_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  imm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (item.command),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd),
    .busy      (busy)
  );

  imm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .dp_cmd        (dp_cmd),
    .dp_status     (dp_status),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

`default_nettype wire
